>>> rtl/fpr_pkg.sv
// Shared types, codes and reset values for the framed packet receiver.
package fpr_pkg;

  // Item kinds carried in the func field.
  localparam logic [1:0] FUNC_BYTE = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_ARM  = 2'd2;

  // Result kinds carried in the out_kind field.
  localparam logic [1:0] KIND_ID     = 2'd0;
  localparam logic [1:0] KIND_LENGTH = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  // Configuration register indexes.
  localparam logic [0:0] REG_TIMEOUT_TICKS = 1'd0;
  localparam logic [0:0] REG_MAX_LENGTH    = 1'd1;

  localparam int          CFG_INDEX_W         = 1;
  localparam int          CFG_DATA_W          = 16;
  localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;
  localparam logic [7:0]  MAX_LENGTH_RESET    = 8'd128;

  typedef enum logic [2:0] {
    PH_ID       = 3'd0,
    PH_LENGTH   = 3'd1,
    PH_DATA     = 3'd2,
    PH_CHECKSUM = 3'd3,
    PH_IGNORE   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] byte_in;
  } fpr_in_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [7:0] data_index;
    logic       status_corrupt;
    logic       last;
  } fpr_out_t;

endpackage

>>> rtl/fpr_core.sv
// Frame parser, checksum and timer state, updated once per accepted request.
module fpr_core import fpr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  fpr_in_t                item,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   res_valid,
  output fpr_out_t               res
);

  logic [15:0] timeout_ticks;
  logic [7:0]  max_length;

  phase_t      phase, phase_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  write_index, write_index_next;
  logic [7:0]  running_xor, running_xor_next;
  logic        armed, armed_next;
  logic        blocked, blocked_next;
  logic        arm_pending, arm_pending_next;
  logic [15:0] timer_count, timer_count_next;
  logic        timer_running, timer_running_next;
  logic        timer_unblocks, timer_unblocks_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_TICKS_RESET;
      max_length    <= MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        REG_MAX_LENGTH:    max_length    <= cfg_data[7:0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_ID;
      bytes_left     <= '0;
      write_index    <= '0;
      running_xor    <= '0;
      armed          <= 1'b0;
      blocked        <= 1'b0;
      arm_pending    <= 1'b0;
      timer_count    <= '0;
      timer_running  <= 1'b0;
      timer_unblocks <= 1'b0;
    end else if (fire) begin
      phase          <= phase_next;
      bytes_left     <= bytes_left_next;
      write_index    <= write_index_next;
      running_xor    <= running_xor_next;
      armed          <= armed_next;
      blocked        <= blocked_next;
      arm_pending    <= arm_pending_next;
      timer_count    <= timer_count_next;
      timer_running  <= timer_running_next;
      timer_unblocks <= timer_unblocks_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    bytes_left_next     = bytes_left;
    write_index_next    = write_index;
    running_xor_next    = running_xor;
    armed_next          = armed;
    blocked_next        = blocked;
    arm_pending_next    = arm_pending;
    timer_count_next    = timer_count;
    timer_running_next  = timer_running;
    timer_unblocks_next = timer_unblocks;
    res_valid           = 1'b0;
    res                 = '0;

    case (item.func)
      FUNC_BYTE: begin
        if (armed) begin
          unique case (phase)
            PH_ID: begin
              timer_count_next    = timeout_ticks;
              timer_running_next  = 1'b1;
              timer_unblocks_next = 1'b0;
              res_valid           = 1'b1;
              res.out_kind        = KIND_ID;
              res.out_byte        = item.byte_in;
              phase_next          = PH_LENGTH;
              running_xor_next    = running_xor ^ item.byte_in;
            end
            PH_LENGTH: begin
              res_valid = 1'b1;
              if (item.byte_in > max_length) begin
                // Bad length: report corrupt and hold off until the unblock timer runs out.
                res.out_kind        = KIND_STATUS;
                res.status_corrupt  = 1'b1;
                res.last            = 1'b1;
                phase_next          = PH_IGNORE;
                blocked_next        = 1'b1;
                armed_next          = 1'b0;
                timer_count_next    = timeout_ticks;
                timer_running_next  = 1'b1;
                timer_unblocks_next = 1'b1;
              end else begin
                res.out_kind     = KIND_LENGTH;
                res.out_byte     = item.byte_in;
                bytes_left_next  = item.byte_in;
                write_index_next = '0;
                phase_next       = (item.byte_in != 8'd0) ? PH_DATA : PH_CHECKSUM;
                running_xor_next = running_xor ^ item.byte_in;
              end
            end
            PH_DATA: begin
              res_valid        = 1'b1;
              res.out_kind     = KIND_DATA;
              res.out_byte     = item.byte_in;
              res.data_index   = write_index;
              write_index_next = write_index + 8'd1;
              bytes_left_next  = bytes_left - 8'd1;
              if (bytes_left == 8'd1) begin
                phase_next = PH_CHECKSUM;
              end
              running_xor_next = running_xor ^ item.byte_in;
            end
            PH_CHECKSUM: begin
              timer_running_next = 1'b0;
              res_valid          = 1'b1;
              res.out_kind       = KIND_STATUS;
              res.status_corrupt = (running_xor != item.byte_in);
              res.last           = 1'b1;
              armed_next         = 1'b0;
              phase_next         = PH_ID;
            end
            default: ;
          endcase
        end
      end
      FUNC_TICK: begin
        if (timer_running) begin
          if (timer_count > 16'd1) begin
            timer_count_next = timer_count - 16'd1;
          end else begin
            timer_count_next   = '0;
            timer_running_next = 1'b0;
            if (timer_unblocks) begin
              timer_unblocks_next = 1'b0;
              phase_next          = PH_ID;
              blocked_next        = 1'b0;
              // An arm that arrived while blocked takes effect now.
              if (arm_pending) begin
                arm_pending_next = 1'b0;
                armed_next       = 1'b1;
                bytes_left_next  = '0;
                write_index_next = '0;
                running_xor_next = '0;
              end
            end else begin
              phase_next         = PH_IGNORE;
              armed_next         = 1'b0;
              res_valid          = 1'b1;
              res.out_kind       = KIND_STATUS;
              res.status_corrupt = 1'b1;
              res.last           = 1'b1;
            end
          end
        end
      end
      FUNC_ARM: begin
        if (blocked) begin
          arm_pending_next = 1'b1;
        end else begin
          armed_next          = 1'b1;
          phase_next          = PH_ID;
          bytes_left_next     = '0;
          write_index_next    = '0;
          running_xor_next    = '0;
          timer_running_next  = 1'b0;
          timer_unblocks_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  a_blocked_not_armed: assert property (@(posedge clk) disable iff (rst)
    blocked |-> !armed) else $error("receiver armed while blocked");

  a_unblock_timer: assert property (@(posedge clk) disable iff (rst)
    timer_unblocks |-> (timer_running && blocked))
    else $error("unblock timer without a running timer and a block");

  a_pending_needs_block: assert property (@(posedge clk) disable iff (rst)
    arm_pending |-> blocked) else $error("arm held while not blocked");

  a_data_phase: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (armed && bytes_left != 8'd0))
    else $error("data phase with nothing left to receive");

endmodule

>>> rtl/fpr_out_fifo.sv
// Two-entry result buffer that parts the input side from the output stall.
module fpr_out_fifo import fpr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  fpr_out_t push_data,
  output logic     full,
  output logic     out_valid,
  input  logic     out_stall,
  output fpr_out_t out_data
);

  fpr_out_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/framed_packet_receiver.sv
// Top level of the framed packet receiver.
// Parses frames of id, length, data bytes and an XOR checksum, one request per
// received byte, timer tick or host arm. Every request is handled in the cycle it
// is accepted, so one request can be taken in every clock while in_stall is low;
// results are registered in a two-entry buffer, and in_stall rises only while
// both entries are held by a stalled output. The user must write the configuration
// registers through cfg_we, cfg_index and cfg_data while the receiver is idle;
// the block does not enforce this. They take effect for the next request.
module framed_packet_receiver import fpr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  fpr_in_t                in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output fpr_out_t               out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic     fire;
  logic     res_valid;
  fpr_out_t res;
  logic     full;

  assign in_stall = full;
  assign fire     = in_valid && !full;

  fpr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  fpr_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fire && res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
